@@ sv/hsvrgb_pkg.sv @@
// ---------------------------------------------------------------------------
// hsvrgb_pkg
// Shared widths, constants and sector codes of the HSV to RGB converter.
// ---------------------------------------------------------------------------
package hsvrgb_pkg;

   // Field widths
   localparam int HUE_W  = 9;
   localparam int PCT_W  = 7;
   localparam int CHAN_W = 8;

   // Intermediate widths: S*V, values at 1/600000 scale, scaled by 255
   localparam int SV_W    = 14;
   localparam int X6_W    = 20;
   localparam int WGT_W   = 6;
   localparam int Y_W     = 28;
   localparam int RECIP_W = 21;
   localparam int PROD_W  = Y_W + RECIP_W;

   // Range limits
   localparam logic [HUE_W-1:0] HUE_MAX = 9'd360;
   localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

   // Sector boundaries and hue folding
   localparam logic [HUE_W-1:0] HUE_60  = 9'd60;
   localparam logic [HUE_W-1:0] HUE_120 = 9'd120;
   localparam logic [HUE_W-1:0] HUE_180 = 9'd180;
   localparam logic [HUE_W-1:0] HUE_240 = 9'd240;
   localparam logic [HUE_W-1:0] HUE_300 = 9'd300;
   localparam logic [PCT_W-1:0] HM_MID  = 7'd60;

   // Scaling constants
   localparam logic [X6_W-1:0] CHROMA_MUL = 20'd60;
   localparam logic [X6_W-1:0] VALUE_MUL  = 20'd6000;
   localparam logic [Y_W-1:0]  FULL_SCALE = 28'd600000;

   // floor(2^40 / 600000): quotient estimate is exact or one short
   localparam int                 RECIP_SHIFT = 40;
   localparam logic [RECIP_W-1:0] RECIP       = 21'd1832519;

   // Hue sector codes
   typedef logic [2:0] sector_type;
   localparam sector_type SECT_RED_YEL = 3'd0;  // (C,X,0)
   localparam sector_type SECT_YEL_GRN = 3'd1;  // (X,C,0)
   localparam sector_type SECT_GRN_CYN = 3'd2;  // (0,C,X)
   localparam sector_type SECT_CYN_BLU = 3'd3;  // (0,X,C)
   localparam sector_type SECT_BLU_MAG = 3'd4;  // (X,0,C)
   localparam sector_type SECT_MAG_RED = 3'd5;  // (C,0,X)

endpackage

@@ sv/hsv_to_rgb_converter.sv @@
// ---------------------------------------------------------------------------
// hsv_to_rgb_converter
// Integer HSV to RGB colour conversion, five register stages, one pixel
// per clock.
// ---------------------------------------------------------------------------
//
//  channel   ports                                   handshake
//  -------   -------------------------------------   -------------------------
//  request   req_hue, req_saturation, req_brightness start high, busy low
//  result    rsp_red, rsp_green, rsp_blue,           rsp_valid, one cycle
//            rsp_in_range
//
//  A request accepted at one edge moves through the five register stages to its result; one
//  request may be accepted every cycle, so busy is always low.
//  Latency is set by the chain multiply, add, scale by 255 and the
//  reciprocal divide by 600000 with its one-step correction.
//  Synchronous reset clears the valid bits only; no state links pixels.
//  The receiver cannot stall; each result is shown for one cycle.
// ---------------------------------------------------------------------------
module hsv_to_rgb_converter
   import hsvrgb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [HUE_W-1:0]  req_hue,
   input  logic [PCT_W-1:0]  req_saturation,
   input  logic [PCT_W-1:0]  req_brightness,
   output logic              rsp_valid,
   output logic [CHAN_W-1:0] rsp_red,
   output logic [CHAN_W-1:0] rsp_green,
   output logic [CHAN_W-1:0] rsp_blue,
   output logic              rsp_in_range
);

   // ------------------------------------------------------------------
   // Valid and range flags travelling with the data
   // ------------------------------------------------------------------
   logic [4:0] vld_ff, vld_in;
   logic [4:0] rng_ff, rng_in;

   // Stage 1: sector, hue weight, S*V
   sector_type          s1_sect_ff, s1_sect_in;
   logic [WGT_W-1:0]    s1_wgt_ff, s1_wgt_in;
   logic [SV_W-1:0]     s1_sv_ff, s1_sv_in;
   logic [PCT_W-1:0]    s1_v_ff;
   logic [PCT_W-1:0]    hm;
   logic [PCT_W-1:0]    hdev;

   // Stage 2: chroma, second component, offset
   sector_type          s2_sect_ff;
   logic [X6_W-1:0]     s2_c6_ff, s2_c6_in;
   logic [X6_W-1:0]     s2_x6_ff, s2_x6_in;
   logic [X6_W-1:0]     s2_m6_ff, s2_m6_in;

   // Stage 3: channel sums scaled by 255
   logic [Y_W-1:0]      s3_y_ff [3];
   logic [Y_W-1:0]      s3_y_in [3];
   logic [X6_W-1:0]     comp [3];

   // Stage 4: quotient estimates
   logic [Y_W-1:0]      s4_y_ff [3];
   logic [CHAN_W-1:0]   s4_q_ff [3];
   logic [CHAN_W-1:0]   s4_q_in [3];
   logic [PROD_W-1:0]   prod [3];

   // Stage 5: corrected outputs
   logic [CHAN_W-1:0]   s5_q_ff [3];
   logic [CHAN_W-1:0]   s5_q_in [3];
   logic [Y_W-1:0]      rem [3];

   assign busy = 1'b0;

   // Valid and range shift
   always_comb begin
      vld_in = {vld_ff[3:0], start};
      rng_in = {rng_ff[3:0], (req_hue <= HUE_MAX) && (req_saturation <= PCT_MAX)
                             && (req_brightness <= PCT_MAX)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
      rng_ff <= rng_in;
   end

   // ------------------------------------------------------------------
   // Stage 1: fold hue into its sector and take weight 60-|hm-60|
   // ------------------------------------------------------------------
   always_comb begin
      if (req_hue < HUE_60) begin
         s1_sect_in = SECT_RED_YEL;
         hm         = req_hue[PCT_W-1:0];
      end else if (req_hue < HUE_120) begin
         s1_sect_in = SECT_YEL_GRN;
         hm         = req_hue[PCT_W-1:0];
      end else if (req_hue < HUE_180) begin
         s1_sect_in = SECT_GRN_CYN;
         hm         = PCT_W'(req_hue - HUE_120);
      end else if (req_hue < HUE_240) begin
         s1_sect_in = SECT_CYN_BLU;
         hm         = PCT_W'(req_hue - HUE_120);
      end else if (req_hue < HUE_300) begin
         s1_sect_in = SECT_BLU_MAG;
         hm         = PCT_W'(req_hue - HUE_240);
      end else begin
         // hue 360 folds to 120 here, which gives the same zero weight
         s1_sect_in = SECT_MAG_RED;
         hm         = PCT_W'(req_hue - HUE_240);
      end
      hdev      = (hm >= HM_MID) ? (hm - HM_MID) : (HM_MID - hm);
      s1_wgt_in = WGT_W'(HM_MID - hdev);
      s1_sv_in  = SV_W'(req_saturation) * SV_W'(req_brightness);
   end

   always_ff @(posedge clock) begin
      s1_sect_ff <= s1_sect_in;
      s1_wgt_ff  <= s1_wgt_in;
      s1_sv_ff   <= s1_sv_in;
      s1_v_ff    <= req_brightness;
   end

   // ------------------------------------------------------------------
   // Stage 2: chroma6, second6 and m6
   // ------------------------------------------------------------------
   always_comb begin
      s2_c6_in = X6_W'(s1_sv_ff) * CHROMA_MUL;
      s2_x6_in = X6_W'(s1_sv_ff) * X6_W'(s1_wgt_ff);
      s2_m6_in = X6_W'(s1_v_ff) * VALUE_MUL - s2_c6_in;
   end

   always_ff @(posedge clock) begin
      s2_sect_ff <= s1_sect_ff;
      s2_c6_ff   <= s2_c6_in;
      s2_x6_ff   <= s2_x6_in;
      s2_m6_ff   <= s2_m6_in;
   end

   // ------------------------------------------------------------------
   // Stage 3: component order by sector, add offset, scale by 255
   // ------------------------------------------------------------------
   always_comb begin
      unique case (s2_sect_ff)
         SECT_RED_YEL: begin
            comp[0] = s2_c6_ff; comp[1] = s2_x6_ff; comp[2] = '0;
         end
         SECT_YEL_GRN: begin
            comp[0] = s2_x6_ff; comp[1] = s2_c6_ff; comp[2] = '0;
         end
         SECT_GRN_CYN: begin
            comp[0] = '0;       comp[1] = s2_c6_ff; comp[2] = s2_x6_ff;
         end
         SECT_CYN_BLU: begin
            comp[0] = '0;       comp[1] = s2_x6_ff; comp[2] = s2_c6_ff;
         end
         SECT_BLU_MAG: begin
            comp[0] = s2_x6_ff; comp[1] = '0;       comp[2] = s2_c6_ff;
         end
         SECT_MAG_RED: begin
            comp[0] = s2_c6_ff; comp[1] = '0;       comp[2] = s2_x6_ff;
         end
         default: begin
            comp[0] = '0;       comp[1] = '0;       comp[2] = '0;
         end
      endcase
      for (int i = 0; i < 3; i++) begin
         // (t << 8) - t
         s3_y_in[i] = (Y_W'(comp[i] + s2_m6_ff) << 8) - Y_W'(comp[i] + s2_m6_ff);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         s3_y_ff[i] <= s3_y_in[i];
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: quotient estimate by reciprocal multiply
   // ------------------------------------------------------------------
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         prod[i]    = PROD_W'(s3_y_ff[i]) * PROD_W'(RECIP);
         s4_q_in[i] = prod[i][RECIP_SHIFT +: CHAN_W];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         s4_y_ff[i] <= s3_y_ff[i];
         s4_q_ff[i] <= s4_q_in[i];
      end
   end

   // ------------------------------------------------------------------
   // Stage 5: one-step correction, zero on out-of-range request
   // ------------------------------------------------------------------
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rem[i] = s4_y_ff[i] - Y_W'(s4_q_ff[i]) * FULL_SCALE;
         if (!rng_ff[3]) begin
            s5_q_in[i] = '0;
         end else if (rem[i] >= FULL_SCALE) begin
            s5_q_in[i] = s4_q_ff[i] + CHAN_W'(1);
         end else begin
            s5_q_in[i] = s4_q_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         s5_q_ff[i] <= s5_q_in[i];
      end
   end

   // Result ports
   assign rsp_valid    = vld_ff[4];
   assign rsp_red      = s5_q_ff[0];
   assign rsp_green    = s5_q_ff[1];
   assign rsp_blue     = s5_q_ff[2];
   assign rsp_in_range = rng_ff[4];

endmodule

@@ tb/sv/hsvrgb_sb_pkg.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// hsvrgb_sb_pkg
// Colour predictor and scoreboard for the HSV to RGB converter bench. Each
// accepted request is turned into an expected colour in exact integers; the
// results are then matched in order against the queue of those colours.
// ---------------------------------------------------------------------------
package hsvrgb_sb_pkg;
   import hsvrgb_pkg::*;

   // One converted pixel as seen on the result ports
   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic              in_range;
   } colour_type;

   localparam longint unsigned SCALE_DEN = 600000;
   localparam longint unsigned CHAN_MUL  = 255;
   localparam longint unsigned DEG_FOLD  = 120;
   localparam longint unsigned DEG_SPAN  = 60;
   localparam longint unsigned VAL_MUL   = 6000;
   localparam int              REPORT_MAX = 10;

   // Expected colour of one request; all terms at 1/600000 of full scale
   function automatic colour_type predict_colour(input logic [HUE_W-1:0] hue,
                                                 input logic [PCT_W-1:0] sat,
                                                 input logic [PCT_W-1:0] bri);
      colour_type       col;
      longint unsigned  sv, chroma6, second6, offset6, fold, hdev;
      longint unsigned  r6, g6, b6;
      sector_type       sect;
      col = '0;
      // out-of-range request: black with the flag cleared
      if (hue > HUE_MAX || sat > PCT_MAX || bri > PCT_MAX) begin
         return col;
      end
      sv      = longint'(sat) * longint'(bri);
      chroma6 = sv * DEG_SPAN;
      fold    = longint'(hue) % DEG_FOLD;
      hdev    = (fold >= DEG_SPAN) ? fold - DEG_SPAN : DEG_SPAN - fold;
      second6 = sv * (DEG_SPAN - hdev);
      offset6 = longint'(bri) * VAL_MUL - chroma6;

      // hue 360 lands in the last sector
      if (hue < HUE_60)       sect = SECT_RED_YEL;
      else if (hue < HUE_120) sect = SECT_YEL_GRN;
      else if (hue < HUE_180) sect = SECT_GRN_CYN;
      else if (hue < HUE_240) sect = SECT_CYN_BLU;
      else if (hue < HUE_300) sect = SECT_BLU_MAG;
      else                    sect = SECT_MAG_RED;

      case (sect)
         SECT_RED_YEL: begin r6 = chroma6; g6 = second6; b6 = 0;       end
         SECT_YEL_GRN: begin r6 = second6; g6 = chroma6; b6 = 0;       end
         SECT_GRN_CYN: begin r6 = 0;       g6 = chroma6; b6 = second6; end
         SECT_CYN_BLU: begin r6 = 0;       g6 = second6; b6 = chroma6; end
         SECT_BLU_MAG: begin r6 = second6; g6 = 0;       b6 = chroma6; end
         default:      begin r6 = chroma6; g6 = 0;       b6 = second6; end
      endcase

      col.red      = CHAN_W'(((r6 + offset6) * CHAN_MUL) / SCALE_DEN);
      col.green    = CHAN_W'(((g6 + offset6) * CHAN_MUL) / SCALE_DEN);
      col.blue     = CHAN_W'(((b6 + offset6) * CHAN_MUL) / SCALE_DEN);
      col.in_range = 1'b1;
      return col;
   endfunction

   // In-order scoreboard of expected colours
   class colour_scoreboard;
      colour_type  expected_q[$];
      int unsigned mismatch_count;
      int unsigned unexpected_count;
      int unsigned checked_count;
      int unsigned in_range_count;

      function new();
         mismatch_count   = 0;
         unexpected_count = 0;
         checked_count    = 0;
         in_range_count   = 0;
      endfunction

      function int unsigned pending_count();
         return expected_q.size();
      endfunction

      function void note_pixel(input logic [HUE_W-1:0] hue,
                               input logic [PCT_W-1:0] sat,
                               input logic [PCT_W-1:0] bri);
         expected_q.push_back(predict_colour(hue, sat, bri));
      endfunction

      function void check_colour(input colour_type got);
         colour_type want;
         bit         bad;
         // result with nothing outstanding
         if (expected_q.size() == 0) begin
            unexpected_count++;
            if (mismatch_count + unexpected_count <= REPORT_MAX)
               $display("tb_top: unexpected result r=%0d g=%0d b=%0d ok=%0b at %0t",
                        got.red, got.green, got.blue, got.in_range, $time);
            return;
         end
         want = expected_q.pop_front();
         checked_count++;
         if (got.in_range === 1'b1) in_range_count++;
         bad = (got.red !== want.red) || (got.green !== want.green) ||
               (got.blue !== want.blue) || (got.in_range !== want.in_range);
         if (bad) begin
            mismatch_count++;
            if (mismatch_count + unexpected_count <= REPORT_MAX)
               $display("tb_top: mismatch %0t exp %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                        $time, want.red, want.green, want.blue, want.in_range,
                        got.red, got.green, got.blue, got.in_range);
         end
      endfunction
   endclass

endpackage

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Bench for the HSV to RGB converter. Directed pixels at the sector edges
// and range limits, then random pixels, mostly in range, with idle bursts;
// every result is checked in order against an integer colour predictor.
// ---------------------------------------------------------------------------
module tb_top
   import hsvrgb_pkg::*, hsvrgb_sb_pkg::*;
();

   localparam int RANDOM_PIXELS = 1250;
   localparam int QUIET_TAIL    = 150;
   localparam int DRAIN_LIMIT   = 1000;
   localparam int SETTLE_CYCLES = 10;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic [HUE_W-1:0]  req_hue = '0;
   logic [PCT_W-1:0]  req_saturation = '0;
   logic [PCT_W-1:0]  req_brightness = '0;
   logic              busy;
   logic              rsp_valid;
   logic [CHAN_W-1:0] rsp_red;
   logic [CHAN_W-1:0] rsp_green;
   logic [CHAN_W-1:0] rsp_blue;
   logic              rsp_in_range;

   colour_scoreboard colour_sb = new();
   int unsigned      sent_count = 0;
   int unsigned      pause_count = 0;

   always #2 clock = ~clock;

   hsv_to_rgb_converter u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_brightness (req_brightness),
      .rsp_valid      (rsp_valid),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .rsp_in_range   (rsp_in_range)
   );

   // Monitor: sample both channels on the edge that accepts them
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            colour_sb.note_pixel(req_hue, req_saturation, req_brightness);
            sent_count++;
         end
         if (rsp_valid === 1'b1)
            colour_sb.check_colour({rsp_red, rsp_green, rsp_blue, rsp_in_range});
      end
   end

   // Present one request and hold it until accepted
   task automatic send_pixel(input logic [HUE_W-1:0] hue,
                             input logic [PCT_W-1:0] sat,
                             input logic [PCT_W-1:0] bri);
      start          <= 1'b1;
      req_hue        <= hue;
      req_saturation <= sat;
      req_brightness <= bri;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
   endtask

   task automatic idle_cycles(input int unsigned n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // Random pixel: mostly in range, some at sector edges, some full width
   task automatic send_random_pixel();
      int unsigned      pick, k;
      logic [HUE_W-1:0] hue;
      logic [PCT_W-1:0] sat, bri;
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
         hue = HUE_W'($urandom_range(0, 360));
         sat = PCT_W'($urandom_range(0, 100));
         bri = PCT_W'($urandom_range(0, 100));
      end else if (pick == 7) begin
         k   = $urandom_range(0, 6);
         hue = HUE_W'(60 * k - ((k > 0) ? $urandom_range(0, 1) : 0));
         sat = $urandom_range(0, 1) ? PCT_MAX : PCT_W'($urandom_range(0, 100));
         bri = $urandom_range(0, 1) ? PCT_MAX : PCT_W'($urandom_range(0, 100));
      end else begin
         hue = HUE_W'($urandom_range(0, 511));
         sat = PCT_W'($urandom_range(0, 127));
         bri = PCT_W'($urandom_range(0, 127));
      end
      send_pixel(hue, sat, bri);
   endtask

   // Stimulus
   initial begin
      int unsigned drain;
      int unsigned fails;
      bit          idle_on;
      idle_on = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: range limits, sector edges, hue 360, out-of-range fields
      send_pixel(9'd0,   7'd0,   7'd0);
      send_pixel(9'd0,   7'd100, 7'd100);
      send_pixel(9'd30,  7'd100, 7'd100);
      send_pixel(9'd59,  7'd100, 7'd100);
      send_pixel(9'd60,  7'd100, 7'd100);
      send_pixel(9'd119, 7'd100, 7'd100);
      send_pixel(9'd120, 7'd100, 7'd100);
      send_pixel(9'd180, 7'd100, 7'd100);
      send_pixel(9'd240, 7'd100, 7'd100);
      send_pixel(9'd300, 7'd100, 7'd100);
      send_pixel(9'd359, 7'd100, 7'd100);
      send_pixel(9'd360, 7'd100, 7'd100);
      send_pixel(9'd360, 7'd50,  7'd50);
      send_pixel(9'd361, 7'd50,  7'd50);
      send_pixel(9'd511, 7'd127, 7'd127);
      send_pixel(9'd90,  7'd101, 7'd60);
      send_pixel(9'd200, 7'd60,  7'd101);
      send_pixel(9'd10,  7'd127, 7'd0);
      send_pixel(9'd0,   7'd0,   7'd100);
      send_pixel(9'd210, 7'd100, 7'd0);
      send_pixel(9'd90,  7'd50,  7'd75);
      send_pixel(9'd270, 7'd1,   7'd1);
      idle_cycles($urandom_range(1, 17));

      // random pixels; idle bursts switch on and off in stretches
      for (int i = 0; i < RANDOM_PIXELS; i++) begin
         if (i % 100 == 0) idle_on = 1'($urandom_range(0, 1));
         if (i == RANDOM_PIXELS / 2) begin
            // hold off until the pipeline is empty
            idle_cycles(1);
            while (colour_sb.pending_count() != 0) @(posedge clock);
            pause_count++;
         end
         if (idle_on && i < RANDOM_PIXELS - QUIET_TAIL && $urandom_range(0, 3) == 0)
            idle_cycles($urandom_range(1, 17));
         send_random_pixel();
      end
      start <= 1'b0;

      // drain, then a few cycles for any stray strobe
      drain = 0;
      while (colour_sb.pending_count() != 0 && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      fails = colour_sb.mismatch_count + colour_sb.unexpected_count +
              colour_sb.pending_count();
      $display("tb_top: %0d requests sent, %0d results compared, %0d in range",
               sent_count, colour_sb.checked_count, colour_sb.in_range_count);
      $display("tb_top: %0d full drains, %0d mismatches, %0d stray, %0d outstanding",
               pause_count, colour_sb.mismatch_count, colour_sb.unexpected_count,
               colour_sb.pending_count());
      if (fails == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #1000000;
      $display("tb_top: timeout");
      $display("tb_top: errors");
      $finish;
   end

endmodule
